/* rtl/text_to_integer_parser_macros.svh */
// ----------------------------------------------------------------------------
// text_to_integer_parser_macros.svh
// Assertion macros used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_INTEGER_PARSER_MACROS_SVH
`define TEXT_TO_INTEGER_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define TTOI_CHECK(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("ttoi check failed");

// Next-cycle implication, active during reset too.
`define TTOI_CHECK_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) (pre) |=> (post)) \
      else $error("ttoi next-cycle check failed");

`else

`define TTOI_CHECK(label, pre, post)
`define TTOI_CHECK_NEXT(label, pre, post)

`endif

`endif

/* rtl/ttoi_pkg.sv */
// ----------------------------------------------------------------------------
// ttoi_pkg
// Types, constants and helper functions for the text to integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ttoi_pkg;

   localparam int CHAR_W   = 21;
   localparam int BASE_W   = 6;
   localparam int VALUE_W  = 64;
   localparam int COUNT_W  = 32;
   localparam int PHASE_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
   localparam logic [PHASE_W-1:0] PH_SPACE  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd2;
   localparam logic [PHASE_W-1:0] PH_XCHECK = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_NUMBER_BASE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNED_RESULT = 2'd1;

   localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_W-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_W-1:0] BASE_ONE   = 6'd1;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

   localparam logic [CHAR_W-1:0] CH_TAB   = 21'd9;
   localparam logic [CHAR_W-1:0] CH_CR    = 21'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 21'd32;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 21'd43;
   localparam logic [CHAR_W-1:0] CH_MINUS = 21'd45;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 21'd48;
   localparam logic [CHAR_W-1:0] CH_NINE  = 21'd57;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 21'd65;
   localparam logic [CHAR_W-1:0] CH_UP_Z  = 21'd90;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 21'd97;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 21'd120;
   localparam logic [CHAR_W-1:0] CH_LO_Z  = 21'd122;

   localparam logic [VALUE_W-1:0] LONG_MAX_VALUE  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] ULONG_MAX_VALUE = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [PHASE_W-1:0] phase;
      logic               negative;
      logic [BASE_W-1:0]  base;
      logic [VALUE_W-1:0] accumulator;
      logic [COUNT_W-1:0] consumed;
      logic               overflow;
   } parse_state_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] end_offset;
      logic               base_error;
      logic               wrapped;
   } parse_result_type;

   function automatic logic digit_ok(input logic [BASE_W-1:0] b, input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] ext_b;
      logic [CHAR_W-1:0] letters;
      logic              ok;
      ext_b   = CHAR_W'(b);
      letters = ext_b - CHAR_W'(BASE_DEC);
      if (c < CH_ZERO) begin
         ok = 1'b0;
      end else if (b <= BASE_DEC) begin
         ok = (c < CH_ZERO + ext_b);
      end else if (c >= CH_LO_A && c < CH_LO_A + letters) begin
         ok = 1'b1;
      end else if (c >= CH_UP_A && c < CH_UP_A + letters) begin
         ok = 1'b1;
      end else begin
         ok = (c <= CH_NINE);
      end
      return ok;
   endfunction

   function automatic logic [BASE_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] d;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = c - CH_LO_A + CHAR_W'(BASE_DEC);
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = c - CH_UP_A + CHAR_W'(BASE_DEC);
      end
      return d[BASE_W-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/text_to_integer_parser.sv */
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Streaming wide-character string to 64-bit integer parser.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// req       in         req_valid/stall     code_point, start_of_string
// rsp       out        rsp_valid/stall     value, end_offset, base_error, wrapped
// csr       in         csr_valid/ready     csr_index, csr_wdata
//
// One character per cycle while req_stall is low; a stop character's result is
// registered in rsp_ff or skid_ff. The accumulator multiply-add is combinational.
// Synchronous reset: idle, number_base 10, signed_result 1, outputs empty.
// Results go to an output register backed by a skid entry; req_stall rises
// only when both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_to_integer_parser_macros.svh"

module text_to_integer_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ttoi_pkg::CHAR_W-1:0]       req_code_point,
   input  logic                              req_start_of_string,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ttoi_pkg::VALUE_W-1:0]      rsp_value,
   output logic [ttoi_pkg::COUNT_W-1:0]      rsp_end_offset,
   output logic                              rsp_base_error,
   output logic                              rsp_wrapped,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ttoi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ttoi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ttoi_pkg::*;

   logic [BASE_W-1:0] number_base_ff;
   logic              signed_result_ff;
   parse_state_type   state_ff;
   parse_state_type   state_in;
   logic              emit;
   parse_result_type  result;
   parse_result_type  rsp_ff;
   parse_result_type  skid_ff;
   logic              rsp_valid_ff;
   logic              skid_valid_ff;
   logic              req_take;
   logic              rsp_take;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff   <= BASE_RESET;
         signed_result_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_NUMBER_BASE:   number_base_ff   <= csr_wdata[BASE_W-1:0];
            CSR_SIGNED_RESULT: signed_result_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ttoi_step u_step (
      .state_cur       (state_ff),
      .number_base     (number_base_ff),
      .signed_result   (signed_result_ff),
      .code_point      (req_code_point),
      .start_of_string (req_start_of_string),
      .state_nxt       (state_in),
      .emit            (emit),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_take) begin
         rsp_valid_ff <= req_take && emit;
         if (req_take && emit) begin
            rsp_ff <= result;
         end
      end else if (req_take && emit) begin
         skid_ff       <= result;
         skid_valid_ff <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_ff.value;
   assign rsp_end_offset = rsp_ff.end_offset;
   assign rsp_base_error = rsp_ff.base_error;
   assign rsp_wrapped    = rsp_ff.wrapped;

   `TTOI_CHECK(a_skid_behind_rsp, skid_valid_ff, rsp_valid_ff)
   `TTOI_CHECK(a_base_error_clean, rsp_valid_ff && rsp_ff.base_error,
      rsp_ff.end_offset == '0 && !rsp_ff.wrapped)
   `TTOI_CHECK(a_digit_base_valid, state_ff.phase == PH_DIGITS,
      state_ff.base >= 6'd2 && state_ff.base <= BASE_MAX)
   `TTOI_CHECK_NEXT(a_reset_empties, reset,
      !rsp_valid_ff && !skid_valid_ff && state_ff.phase == PH_IDLE)

endmodule

`default_nettype wire

/* rtl/ttoi_step.sv */
// ----------------------------------------------------------------------------
// ttoi_step
// Next-state and result logic for one character of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ttoi_step (
   input  ttoi_pkg::parse_state_type       state_cur,
   input  logic [ttoi_pkg::BASE_W-1:0]     number_base,
   input  logic                            signed_result,
   input  logic [ttoi_pkg::CHAR_W-1:0]     code_point,
   input  logic                            start_of_string,
   output ttoi_pkg::parse_state_type       state_nxt,
   output logic                            emit,
   output ttoi_pkg::parse_result_type      result
);
   import ttoi_pkg::*;

   logic [PHASE_W-1:0]   phase;
   logic                 take;
   logic                 go_prefix;
   logic                 go_digits;
   logic                 is_space;
   logic                 is_sign;
   logic [VALUE_W+BASE_W-1:0] product;
   logic [VALUE_W:0]     sum;

   assign is_space = (code_point == CH_SPACE) || (code_point >= CH_TAB && code_point <= CH_CR);
   assign is_sign  = (code_point == CH_MINUS) || (code_point == CH_PLUS);

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      result    = '0;
      take      = 1'b0;
      go_prefix = 1'b0;
      go_digits = 1'b0;
      product   = '0;
      sum       = '0;
      phase     = state_cur.phase;

      if (start_of_string) begin
         state_nxt.negative    = 1'b0;
         state_nxt.accumulator = '0;
         state_nxt.consumed    = '0;
         state_nxt.overflow    = 1'b0;
         state_nxt.base        = number_base;
         if (number_base == BASE_ONE || number_base > BASE_MAX) begin
            state_nxt.phase   = PH_IDLE;
            phase             = PH_IDLE;
            emit              = 1'b1;
            result.value      = signed_result ? LONG_MAX_VALUE : ULONG_MAX_VALUE;
            result.base_error = 1'b1;
         end else begin
            state_nxt.phase = PH_SPACE;
            phase           = PH_SPACE;
         end
      end

      unique case (phase)
         PH_SPACE: begin
            if (is_space) begin
               take = 1'b1;
            end else if (is_sign) begin
               state_nxt.negative = (code_point == CH_MINUS);
               state_nxt.phase    = PH_PREFIX;
               take               = 1'b1;
            end else begin
               go_prefix = 1'b1;
            end
         end
         PH_PREFIX: begin
            go_prefix = 1'b1;
         end
         PH_XCHECK: begin
            state_nxt.phase = PH_DIGITS;
            if (code_point == CH_LO_X) begin
               state_nxt.base = BASE_HEX;
               take           = 1'b1;
            end else begin
               go_digits = 1'b1;
            end
         end
         PH_DIGITS: begin
            go_digits = 1'b1;
         end
         default: begin
            state_nxt.phase = PH_IDLE;
         end
      endcase

      if (go_prefix) begin
         state_nxt.phase = PH_DIGITS;
         if (state_nxt.base == BASE_HEX && code_point == CH_ZERO) begin
            state_nxt.phase = PH_XCHECK;
            take            = 1'b1;
         end else if (state_nxt.base == BASE_AUTO) begin
            if (code_point == CH_ZERO) begin
               state_nxt.base  = BASE_OCT;
               state_nxt.phase = PH_XCHECK;
               take            = 1'b1;
            end else begin
               state_nxt.base = BASE_DEC;
               go_digits      = 1'b1;
            end
         end else begin
            go_digits = 1'b1;
         end
      end

      if (go_digits) begin
         if (digit_ok(state_nxt.base, code_point)) begin
            product = (VALUE_W+BASE_W)'(state_nxt.accumulator)
                    * (VALUE_W+BASE_W)'(state_nxt.base);
            sum     = (VALUE_W+1)'(product[VALUE_W-1:0])
                    + (VALUE_W+1)'(digit_value(code_point));
            state_nxt.accumulator = sum[VALUE_W-1:0];
            state_nxt.overflow    = state_nxt.overflow
                                  | (product[VALUE_W+BASE_W-1:VALUE_W] != '0)
                                  | sum[VALUE_W];
            state_nxt.phase       = PH_DIGITS;
            take                  = 1'b1;
         end else begin
            state_nxt.phase   = PH_IDLE;
            emit              = 1'b1;
            result.value      = state_nxt.negative ? (VALUE_W'(0) - state_nxt.accumulator)
                                                   : state_nxt.accumulator;
            result.end_offset = state_nxt.consumed;
            result.wrapped    = state_nxt.overflow;
         end
      end

      if (take && state_nxt.consumed != '1) begin
         state_nxt.consumed = state_nxt.consumed + COUNT_W'(1);
      end
   end

endmodule

`default_nettype wire

/* verif/text_to_integer_parser_checker.sv */
// ----------------------------------------------------------------------------
// text_to_integer_parser_checker
// Watches the request, result and register channels of the parser, keeps its
// own model of the parse state and compares every result, field by field, with
// the oldest predicted number. Hands the failure count and the number of
// predicted results still outstanding to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_to_integer_parser_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [ttoi_pkg::CHAR_W-1:0]       req_code_point,
   input  logic                              req_start_of_string,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [ttoi_pkg::VALUE_W-1:0]      rsp_value,
   input  logic [ttoi_pkg::COUNT_W-1:0]      rsp_end_offset,
   input  logic                              rsp_base_error,
   input  logic                              rsp_wrapped,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [ttoi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ttoi_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int                                failures,
   output int                                outstanding
);
   import ttoi_pkg::*;

   logic [BASE_W-1:0]  cfg_base;
   logic               cfg_signed;

   logic [PHASE_W-1:0] phase;
   logic               sign_minus;
   logic [BASE_W-1:0]  radix;
   logic [VALUE_W-1:0] acc;
   logic [COUNT_W-1:0] used;
   logic               wrap_seen;

   parse_result_type   parsed_numbers[$];
   int                 fails = 0;

   function automatic int unsigned char_weight(input logic [CHAR_W-1:0] ch);
      int unsigned w;
      w = 99;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         w = 32'(ch - CH_ZERO);
      end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
         w = 32'(ch - CH_LO_A) + 10;
      end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
         w = 32'(ch - CH_UP_A) + 10;
      end
      return w;
   endfunction

   task automatic take_char();
      if (used != '1) begin
         used = used + COUNT_W'(1);
      end
   endtask

   task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic first);
      parse_result_type   res;
      logic               done;
      int unsigned        w;
      logic [127:0]       prod;
      logic [VALUE_W:0]   sum;
      done = 1'b0;
      if (first) begin
         sign_minus = 1'b0;
         acc        = '0;
         used       = '0;
         wrap_seen  = 1'b0;
         radix      = cfg_base;
         phase      = PH_SPACE;
         if (radix == BASE_ONE || radix > BASE_MAX) begin
            phase          = PH_IDLE;
            res.value      = cfg_signed ? LONG_MAX_VALUE : ULONG_MAX_VALUE;
            res.end_offset = '0;
            res.base_error = 1'b1;
            res.wrapped    = 1'b0;
            parsed_numbers.push_back(res);
            done = 1'b1;
         end
      end
      while (!done) begin
         case (phase)
            PH_SPACE: begin
               if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
                  take_char();
                  done = 1'b1;
               end else begin
                  phase = PH_PREFIX;
                  if (ch == CH_MINUS || ch == CH_PLUS) begin
                     sign_minus = (ch == CH_MINUS);
                     take_char();
                     done = 1'b1;
                  end
               end
            end
            PH_PREFIX: begin
               phase = PH_DIGITS;
               if (radix == BASE_HEX && ch == CH_ZERO) begin
                  take_char();
                  phase = PH_XCHECK;
                  done  = 1'b1;
               end else if (radix == BASE_AUTO) begin
                  if (ch == CH_ZERO) begin
                     radix = BASE_OCT;
                     take_char();
                     phase = PH_XCHECK;
                     done  = 1'b1;
                  end else begin
                     radix = BASE_DEC;
                  end
               end
            end
            PH_XCHECK: begin
               phase = PH_DIGITS;
               if (ch == CH_LO_X) begin
                  radix = BASE_HEX;
                  take_char();
                  done = 1'b1;
               end
            end
            PH_DIGITS: begin
               w = char_weight(ch);
               if (w < radix) begin
                  prod = 128'(acc) * 128'(radix);
                  sum  = {1'b0, prod[VALUE_W-1:0]} + (VALUE_W+1)'(w);
                  if (prod[127:VALUE_W] != '0 || sum[VALUE_W]) begin
                     wrap_seen = 1'b1;
                  end
                  acc = sum[VALUE_W-1:0];
                  take_char();
               end else begin
                  phase          = PH_IDLE;
                  res.value      = sign_minus ? VALUE_W'(0) - acc : acc;
                  res.end_offset = used;
                  res.base_error = 1'b0;
                  res.wrapped    = wrap_seen;
                  parsed_numbers.push_back(res);
               end
               done = 1'b1;
            end
            default: begin
               phase = PH_IDLE;
               done  = 1'b1;
            end
         endcase
      end
   endtask

   task automatic report(input string field, input logic [VALUE_W-1:0] want_v,
                         input logic [VALUE_W-1:0] got_v);
      fails++;
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
   endtask

   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         cfg_base   = BASE_RESET;
         cfg_signed = 1'b1;
         phase      = PH_IDLE;
         sign_minus = 1'b0;
         radix      = '0;
         acc        = '0;
         used       = '0;
         wrap_seen  = 1'b0;
         parsed_numbers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parsed_numbers.size() == 0) begin
               fails++;
               $error("result with no pending request: value %0h", rsp_value);
            end else begin
               want = parsed_numbers.pop_front();
               if (rsp_value !== want.value) begin
                  report("value", want.value, rsp_value);
               end
               if (rsp_end_offset !== want.end_offset) begin
                  report("end_offset", VALUE_W'(want.end_offset), VALUE_W'(rsp_end_offset));
               end
               if (rsp_base_error !== want.base_error) begin
                  report("base_error", VALUE_W'(want.base_error), VALUE_W'(rsp_base_error));
               end
               if (rsp_wrapped !== want.wrapped) begin
                  report("wrapped", VALUE_W'(want.wrapped), VALUE_W'(rsp_wrapped));
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NUMBER_BASE:   cfg_base   = csr_wdata[BASE_W-1:0];
               CSR_SIGNED_RESULT: cfg_signed = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            parse_char(req_code_point, req_start_of_string);
         end
      end
      failures    <= fails;
      outstanding <= parsed_numbers.size();
   end

endmodule

/* verif/text_to_integer_parser_tb.sv */
// ----------------------------------------------------------------------------
// text_to_integer_parser_tb
// Streams strings of wide characters into the parser: a short directed set of
// corner cases, then random well-formed numbers in each base_plan setting, mixed
// with noise, truncated strings and trailing junk. Both channels idle at
// random. The checker beside the block predicts and compares the results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_to_integer_parser_tb;
   import ttoi_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 11;
   localparam int PHASE_ITEMS    = 135;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CHAR_W-1:0]     req_code_point = '0;
   logic                  req_start_of_string = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_W-1:0]    rsp_value;
   logic [COUNT_W-1:0]    rsp_end_offset;
   logic                  rsp_base_error;
   logic                  rsp_wrapped;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    failures;
   int                    outstanding;
   int                    idle_cycles = 0;
   int                    stall_left = 0;
   logic                  stall_mode = 1'b0;
   bit                    steady = 1'b0;
   int                    body_len;
   logic [CHAR_W-1:0]     text_q[$];

   logic [BASE_W-1:0] base_plan [PHASES] = '{BASE_DEC, BASE_AUTO, BASE_HEX, 6'd2, BASE_MAX,
                                            BASE_OCT, BASE_ONE, 6'd37, 6'd63, 6'd35, 6'd3};
   logic              sign_plan [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0,
                                            1'b1, 1'b0, 1'b1, 1'b0};

   text_to_integer_parser u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_code_point      (req_code_point),
      .req_start_of_string (req_start_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value           (rsp_value),
      .rsp_end_offset      (rsp_end_offset),
      .rsp_base_error      (rsp_base_error),
      .rsp_wrapped         (rsp_wrapped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   text_to_integer_parser_checker u_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_code_point      (req_code_point),
      .req_start_of_string (req_start_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value           (rsp_value),
      .rsp_end_offset      (rsp_end_offset),
      .rsp_base_error      (rsp_base_error),
      .rsp_wrapped         (rsp_wrapped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .failures            (failures),
      .outstanding         (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure: runs of stall and of free flow
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = ($urandom_range(0, 99) < 35);
         if (stall_mode) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
         end else begin
            stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(1, 6);
         end
      end
      rsp_stall <= stall_mode;
      stall_left = stall_left - 1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   function automatic int req_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [CHAR_W-1:0] random_char();
      if ($urandom_range(0, 1) == 0) return CHAR_W'($urandom_range(0, 127));
      return CHAR_W'($urandom_range(0, 1114111));
   endfunction

   function automatic logic [CHAR_W-1:0] space_char();
      int k;
      k = $urandom_range(9, 14);
      return (k == 14) ? CH_SPACE : CHAR_W'(k);
   endfunction

   function automatic logic [CHAR_W-1:0] digit_char(input int radix);
      int v;
      v = $urandom_range(0, radix - 1);
      if (v < 10) return CH_ZERO + CHAR_W'(v);
      if ($urandom_range(0, 1) == 0) return CH_LO_A + CHAR_W'(v - 10);
      return CH_UP_A + CHAR_W'(v - 10);
   endfunction

   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic first);
      int gap;
      gap = req_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_code_point      <= ch;
      req_start_of_string <= first;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_text(input string s, input logic [CHAR_W-1:0] stop);
      for (int i = 0; i < s.len(); i++) begin
         send_char(CHAR_W'(s[i]), i == 0);
      end
      send_char(stop, s.len() == 0);
   endtask

   task automatic send_queue();
      foreach (text_q[i]) begin
         send_char(text_q[i], i == 0);
      end
   endtask

   // drain: nothing predicted is left, then give the block time to go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic set_config(input logic [BASE_W-1:0] base, input logic sgn);
      settle();
      csr_write(CSR_NUMBER_BASE, base);
      csr_write(CSR_SIGNED_RESULT, {5'($urandom), sgn});
      csr_valid <= 1'b0;
   endtask

   task automatic build_string(input logic [BASE_W-1:0] base, input bit closing);
      int radix;
      int n;
      int roll;
      text_q.delete();
      steady = ($urandom_range(0, 3) == 0);
      radix  = base;
      if (!closing && $urandom_range(0, 99) < 12) begin
         n = $urandom_range(1, 6);
         repeat (n) text_q.push_back(random_char());
      end else begin
         if ($urandom_range(0, 9) >= 7) begin
            n = $urandom_range(1, 3);
            repeat (n) text_q.push_back(space_char());
         end
         roll = $urandom_range(0, 2);
         if (roll == 1) text_q.push_back(CH_PLUS);
         if (roll == 2) text_q.push_back(CH_MINUS);
         roll = $urandom_range(0, 3);
         if (base == BASE_AUTO) begin
            radix = (roll == 0) ? 8 : (roll == 1) ? 16 : 10;
            if (radix != 10) text_q.push_back(CH_ZERO);
            if (radix == 16) text_q.push_back(CH_LO_X);
         end else if (base == BASE_HEX && roll < 2) begin
            text_q.push_back(CH_ZERO);
            if (roll == 0) text_q.push_back(CH_LO_X);
         end
         if (radix < 2 || radix > 36) radix = 10;
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70) : $urandom_range(0, 12);
         repeat (n) text_q.push_back(digit_char(radix));
         roll = $urandom_range(0, 99);
         if (closing || roll < 46) begin
            text_q.push_back('0);
         end else if (roll < 92) begin
            text_q.push_back(random_char());
         end
      end
      body_len = text_q.size();
      if (!closing && $urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 3);
         repeat (n) text_q.push_back(random_char());
      end
   endtask

   initial begin
      int budget;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corner cases, reset config: base 10, signed error value
      send_text(" \t-9", '0);
      send_text("+", 21'h10FFFF);
      send_char(21'h0F0000, 1'b0);
      send_char(CH_ZERO + 21'd1, 1'b1);
      send_char(CH_ZERO + 21'd2, 1'b1);
      send_char(21'd8, 1'b0);
      set_config(BASE_HEX, 1'b1);
      send_text("0xF", CH_LO_A + 21'd6);
      send_text("0X", '0);
      set_config(BASE_AUTO, 1'b0);
      send_text("07", CH_ZERO + 21'd8);
      set_config(BASE_ONE, 1'b0);
      send_char(CH_ZERO + 21'd5, 1'b1);
      set_config(6'd37, 1'b1);
      send_char('0, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         set_config(base_plan[p], sign_plan[p]);
         budget = 0;
         while (budget < PHASE_ITEMS) begin
            build_string(base_plan[p], 1'b0);
            budget += text_q.size();
            send_queue();
         end
         build_string(base_plan[p], 1'b1);
         send_queue();
      end

      settle();
      if (failures == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
